// ===== hdl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the character table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int SLOTS = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] PHASE_HOLD = 2'd3;

	typedef logic [7:0] seg_t;
	typedef logic [2:0] sel_t;
	typedef logic [1:0] slot_t;

	typedef struct packed {
		seg_t segments;
		sel_t digit_select;
	} result_t;

	function automatic seg_t glyph_of(input logic [7:0] code);
		seg_t g;
		case (code) inside
			8'h30: g = 8'h6F;
			8'h31: g = 8'h0A;
			8'h32: g = 8'hE3;
			8'h33: g = 8'hEA;
			8'h34: g = 8'h8E;
			8'h35: g = 8'hEC;
			8'h36: g = 8'hED;
			8'h37: g = 8'h4A;
			8'h38: g = 8'hEF;
			8'h39: g = 8'hEE;
			8'h61, 8'h41: g = 8'h4F;
			8'h76, 8'h56: g = 8'h2F;
			8'h63, 8'h43: g = 8'h65;
			8'h64, 8'h44: g = 8'hAB;
			8'h74, 8'h54: g = 8'hA5;
			8'h65, 8'h45: g = 8'hE5;
			8'h68, 8'h48: g = 8'h8F;
			8'h6C, 8'h4C: g = 8'h25;
			8'h6F, 8'h4F: g = 8'hA9;
			8'h70, 8'h50: g = 8'hC7;
			8'h69, 8'h49: g = 8'h01;
			8'h72, 8'h52: g = 8'h88;
			8'h66, 8'h46: g = 8'hC5;
			8'h6E, 8'h4E: g = 8'h89;
			8'h2D: g = 8'h80;
			8'h00: g = 8'h00;
			8'd10: g = 8'hF7;
			8'd11: g = 8'h31;
			8'd12: g = 8'hDB;
			8'd13: g = 8'h7B;
			8'd14: g = 8'h3D;
			8'd15: g = 8'h7E;
			8'd16: g = 8'hFE;
			8'd17: g = 8'h33;
			8'd18: g = 8'hFF;
			8'd19: g = 8'h7F;
			default: g = code;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/ssd_core.sv =====
// ----------------------------------------------------------------------------
// ssd_core
// Character slots, scan phase and held drive pattern; produces one result
// per accepted request.
// ----------------------------------------------------------------------------
module ssd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             operation,
	input  ssd_pkg::slot_t   slot,
	input  logic [7:0]       char_code,
	output ssd_pkg::result_t result
);
	import ssd_pkg::*;

	logic [7:0] char_store_q [SLOTS];
	logic [1:0] phase_q;
	seg_t       seg_hold_q;
	sel_t       sel_hold_q;

	logic [1:0] phase_next;
	seg_t       seg_next;
	sel_t       sel_next;

	always_comb begin
		phase_next = phase_q;
		seg_next   = seg_hold_q;
		sel_next   = sel_hold_q;
		if (operation == OP_TICK) begin
			phase_next = phase_q + 2'd1;
			if (phase_next != PHASE_HOLD) begin
				seg_next = glyph_of(char_store_q[phase_next]);
				sel_next = sel_t'(3'b001 << phase_next);
			end
		end
	end

	assign result.segments     = seg_next;
	assign result.digit_select = sel_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				char_store_q[i] <= 8'h00;
			end
			phase_q    <= 2'd0;
			seg_hold_q <= '0;
			sel_hold_q <= '0;
		end else if (accept) begin
			if (operation == OP_WRITE) begin
				char_store_q[slot] <= char_code;
			end
			phase_q    <= phase_next;
			seg_hold_q <= seg_next;
			sel_hold_q <= sel_next;
		end
	end

	a_sel_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_hold_q))
		else $error("digit select not one-hot");

	a_write_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_WRITE |=> $stable(phase_q) && $stable(sel_hold_q))
		else $error("write moved the scan");

	a_wrap_to_digit0: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_TICK && phase_q == PHASE_HOLD |=> sel_hold_q == 3'b001)
		else $error("scan wrap did not select digit 0");

	a_hold_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_TICK && phase_q == 2'd2 |=> $stable(seg_hold_q))
		else $error("hold phase changed segments");

endmodule

// ===== hdl/ssd_out_buf.sv =====
// ----------------------------------------------------------------------------
// ssd_out_buf
// Two-entry result buffer separating the request side from the result side.
// ----------------------------------------------------------------------------
module ssd_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssd_pkg::result_t push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output ssd_pkg::result_t head
);
	import ssd_pkg::*;

	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = count_q != 2'd0;
	assign can_push  = count_q != 2'd2;
	assign pop       = out_valid && out_ready;
	assign head      = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				ent0_q <= push_data;
			end else begin
				ent0_q <= ent1_q;
			end
			if (push && count_q == 2'd2) begin
				ent1_q <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				ent0_q <= push_data;
			end else begin
				ent1_q <= push_data;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer overflow");

endmodule

// ===== hdl/seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed three-digit seven-segment driver with four character slots.
// ----------------------------------------------------------------------------
// Every request (a slot write or a refresh tick) returns exactly one result
// carrying the segment pattern and one-hot digit select being driven after
// that request. A request is taken every cycle: the slot store, scan phase and
// character lookup update in the cycle of acceptance and the result enters a
// two-entry output buffer, so in_ready stays high unless two results are
// waiting. Each result is registered in the output buffer at acceptance.
module seven_segment_scan_driver (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           operation,
	input  ssd_pkg::slot_t slot,
	input  logic [7:0]     char_code,
	output logic           out_valid,
	input  logic           out_ready,
	output ssd_pkg::seg_t  segments,
	output ssd_pkg::sel_t  digit_select
);
	import ssd_pkg::*;

	logic    accept;
	result_t core_result;
	result_t head;

	assign accept = in_valid && in_ready;

	ssd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.slot      (slot),
		.char_code (char_code),
		.result    (core_result)
	);

	ssd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_result),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign segments     = head.segments;
	assign digit_select = head.digit_select;

endmodule
